// ----- hdl/ipa_pkg.sv -----
// Package for the ingress port allocator: field widths, request kinds, policy codes,
// configuration register indexes and reset values.
// Used by ipa_port_pick and ingress_port_allocator; depends on nothing.
`default_nettype none

package ipa_pkg;

  localparam int PortCountDefault = 4;
  localparam int MaskBits         = 4;
  localparam int CountW           = 5;
  localparam int PolicyW          = 2;
  localparam int KindW            = 2;
  localparam int CoreW            = 8;
  localparam int AddrW            = 48;
  localparam int GrantPortW       = 2;
  localparam int CfgW             = 5;
  localparam int CfgIdxW          = 1;

  typedef enum logic [KindW-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOGIC = 2'd2,
    KIND_RSVD  = 2'd3
  } req_kind_e;

  typedef enum logic [PolicyW-1:0] {
    POL_FIRST_FREE  = 2'd0,
    POL_CORE_MAPPED = 2'd1,
    POL_ROUND_ROBIN = 2'd2,
    POL_RSVD        = 2'd3
  } port_policy_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PORT_POLICY = 1'd0,
    CFG_BEATS       = 1'd1
  } cfg_index_e;

  localparam logic [PolicyW-1:0] PolicyReset = POL_FIRST_FREE;
  localparam logic [CountW-1:0]  BeatsReset  = 5'd4;

endpackage

`default_nettype wire

// ----- hdl/ipa_port_pick.sv -----
// Port selection for the ingress port allocator: first free, core-mapped and
// round-robin picks over the vector of available ports.
// Depends on ipa_pkg.
`default_nettype none

module ipa_port_pick
  import ipa_pkg::*;
#(
  parameter int PORT_COUNT = PortCountDefault,
  localparam int IdxW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
  input  logic [PORT_COUNT-1:0] avail_i,
  input  logic [PolicyW-1:0]    policy_i,
  input  logic [CoreW-1:0]      core_id_i,
  input  logic [IdxW-1:0]       rr_ptr_i,
  output logic                  hit_o,
  output logic [IdxW-1:0]       port_o,
  output logic [IdxW-1:0]       rr_next_o
);

  // Core number to port: a constant table of core_id modulo the port count.
  function automatic logic [IdxW-1:0] core_port(input logic [CoreW-1:0] core);
    logic [IdxW-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << CoreW); k++) begin
      if (core == CoreW'(k)) r = IdxW'(k % PORT_COUNT);
    end
    return r;
  endfunction

  logic            ff_hit;
  logic [IdxW-1:0] ff_port;
  logic            rr_hit;
  logic [IdxW-1:0] rr_port;
  logic [IdxW-1:0] cm_port;

  always_comb begin
    ff_hit  = 1'b0;
    ff_port = '0;
    for (int i = PORT_COUNT - 1; i >= 0; i--) begin
      if (avail_i[i]) begin
        ff_hit  = 1'b1;
        ff_port = IdxW'(i);
      end
    end
  end

  // Round robin: the lowest available port at or above the pointer wins,
  // otherwise the lowest available port below it.
  always_comb begin
    rr_hit  = 1'b0;
    rr_port = '0;
    for (int i = PORT_COUNT - 1; i >= 0; i--) begin
      if (avail_i[i] && (IdxW'(i) >= rr_ptr_i)) begin
        rr_hit  = 1'b1;
        rr_port = IdxW'(i);
      end
    end
    if (!rr_hit) begin
      rr_hit  = ff_hit;
      rr_port = ff_port;
    end
  end

  assign cm_port = core_port(core_id_i);

  always_comb begin
    hit_o     = 1'b0;
    port_o    = '0;
    rr_next_o = rr_ptr_i;
    case (policy_i)
      POL_FIRST_FREE: begin
        hit_o  = ff_hit;
        port_o = ff_port;
      end
      POL_CORE_MAPPED: begin
        hit_o  = avail_i[cm_port];
        port_o = cm_port;
      end
      POL_ROUND_ROBIN: begin
        hit_o  = rr_hit;
        port_o = rr_port;
        if (rr_hit) begin
          if ({1'b0, rr_port} == (IdxW + 1)'(PORT_COUNT - 1)) begin
            rr_next_o = '0;
          end else begin
            rr_next_o = rr_port + IdxW'(1);
          end
        end
      end
      default: begin
        hit_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/ingress_port_allocator.sv -----
// Top level of the ingress port allocator: stream channels, configuration
// registers, port occupancy state and the result register.
// Depends on ipa_pkg and ipa_port_pick.
`default_nettype none

// Usage
// The slave stream carries one item per transfer: a new memory request
// (tuser func = 0) or one tick of port time (func = 1). Each item yields
// exactly one result on the master stream, in the cycle after its transfer.
// A read, write or logic request wins a port whose occupancy counter is zero
// and its queue-full bit is clear; the configured policy (first free,
// core-mapped or round robin) chooses among such ports. A granted read holds
// the port for one beat, a write or logic operation for beats_per_packet
// beats. A tick counts every occupancy down and reports in push_mask which
// ports finished their header.
// Throughput is one item per cycle while the receiver does not stall: the port
// pick is a combinational select over the availability vector, and the state
// is updated in the same cycle as the transfer.
// When the receiver stalls, the result register holds its item and the slave
// side still takes a new item in the cycle the held result is transferred.
// Reset clears all counters, headers and the round-robin pointer, and sets the
// policy to first free and beats_per_packet to four. Configuration is written by
// the user through cfg_we_i / cfg_idx_i / cfg_data_i while idle; not enforced.

module ingress_port_allocator
  import ipa_pkg::*;
#(
  parameter int PORT_COUNT = PortCountDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // Request stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata, lowest bit up: core_id[7:0], req_addr[55:8], queue_full_mask[59:56], zero pad.
  input  logic [63:0]        s_axis_tdata,
  // tuser, lowest bit up: func[0], req_kind[2:1].
  input  logic [2:0]         s_axis_tuser,
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata, lowest bit up: granted_port[1:0], grant_addr[49:2], push_mask[53:50],
  // free_mask[57:54], zero pad.
  output logic [63:0]        m_axis_tdata,
  // tuser, lowest bit up: accepted[0], grant_kind[2:1].
  output logic [2:0]         m_axis_tuser
);

  localparam int IdxW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  // Input field decode.
  logic                in_func;
  logic [KindW-1:0]    in_kind;
  logic [CoreW-1:0]    in_core;
  logic [AddrW-1:0]    in_addr;
  logic [MaskBits-1:0] in_full;

  assign in_func = s_axis_tuser[0];
  assign in_kind = s_axis_tuser[2:1];
  assign in_core = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[55:8];
  assign in_full = s_axis_tdata[59:56];

  // Configuration registers.
  logic [PolicyW-1:0] policy_q;
  logic [CountW-1:0]  beats_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolicyReset;
      beats_q  <= BeatsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PORT_POLICY: policy_q <= cfg_data_i[PolicyW-1:0];
        CFG_BEATS:       beats_q  <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Port state.
  logic [CountW-1:0]     busy_q [PORT_COUNT];
  logic [CountW-1:0]     busy_d [PORT_COUNT];
  logic [PORT_COUNT-1:0] pend_q, pend_d;
  logic [IdxW-1:0]       rr_q, rr_d;

  // Output register.
  logic                  out_valid_q;
  logic                  out_acc_q, out_acc_d;
  logic [GrantPortW-1:0] out_port_q, out_port_d;
  logic [AddrW-1:0]      out_addr_q, out_addr_d;
  logic [KindW-1:0]      out_kind_q, out_kind_d;
  logic [MaskBits-1:0]   out_push_q, out_push_d;
  logic [MaskBits-1:0]   out_free_q, out_free_d;

  logic xfer;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign xfer          = s_axis_tvalid && s_axis_tready;

  // A port is available when idle and its queue is not full; ports beyond
  // the mask width have no full bit.
  logic [PORT_COUNT-1:0] avail;
  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      avail[i] = (busy_q[i] == '0);
      if (i < MaskBits) begin
        if (in_full[i % MaskBits]) avail[i] = 1'b0;
      end
    end
  end

  logic            pick_hit;
  logic [IdxW-1:0] pick_port;
  logic [IdxW-1:0] pick_rr_next;

  ipa_port_pick #(
    .PORT_COUNT(PORT_COUNT)
  ) u_pick (
    .avail_i   (avail),
    .policy_i  (policy_q),
    .core_id_i (in_core),
    .rr_ptr_i  (rr_q),
    .hit_o     (pick_hit),
    .port_o    (pick_port),
    .rr_next_o (pick_rr_next)
  );

  logic              kind_ok;
  logic              grant;
  logic [CountW-1:0] beats;

  assign kind_ok = (in_kind == KIND_READ) || (in_kind == KIND_WRITE) ||
                   (in_kind == KIND_LOGIC);
  assign grant   = !in_func && kind_ok && pick_hit;
  // A zero beat count acts as one beat.
  assign beats   = (beats_q == '0) ? CountW'(1) : beats_q;

  always_comb begin
    busy_d     = busy_q;
    pend_d     = pend_q;
    rr_d       = rr_q;
    out_acc_d  = 1'b0;
    out_port_d = '0;
    out_addr_d = '0;
    out_kind_d = '0;
    out_push_d = '0;

    if (in_func) begin
      // Tick: report finished headers and count occupancy down.
      for (int i = 0; i < PORT_COUNT; i++) begin
        if (i < MaskBits) out_push_d[i % MaskBits] = pend_q[i];
        if (busy_q[i] != '0) busy_d[i] = busy_q[i] - CountW'(1);
      end
      pend_d = '0;
    end else if (grant) begin
      pend_d[pick_port] = 1'b1;
      busy_d[pick_port] = (in_kind == KIND_READ) ? CountW'(1) : beats;
      rr_d              = pick_rr_next;
      out_acc_d         = 1'b1;
      out_port_d        = GrantPortW'(pick_port);
      out_addr_d        = in_addr;
      out_kind_d        = in_kind;
    end

    out_free_d = '0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      if (i < MaskBits) out_free_d[i % MaskBits] = (busy_d[i] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) busy_q[i] <= '0;
      pend_q      <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        busy_q <= busy_d;
        pend_q <= pend_d;
        rr_q   <= rr_d;
      end
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it only changes on a transfer.
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_acc_q  <= out_acc_d;
      out_port_q <= out_port_d;
      out_addr_q <= out_addr_d;
      out_kind_q <= out_kind_d;
      out_push_q <= out_push_d;
      out_free_q <= out_free_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_free_q, out_push_q, out_addr_q, out_port_q};
  assign m_axis_tuser  = {out_kind_q, out_acc_q};

endmodule

`default_nettype wire
